### src/salc_pkg.sv
// Package for the set-associative LRU cache tag model.
// Holds item structs, configuration indexes and size constants; no dependencies.
package salc_pkg;
    localparam int MAX_SETS_DEF = 1024;
    localparam int MAX_WAYS_DEF = 8;
    localparam int TAG_W = 64;
    localparam int STAMP_W = 32;
    localparam int CNT_W = 32;

    localparam logic [1:0] CFG_SET_BITS = 2'd0;
    localparam logic [1:0] CFG_OFF_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS = 2'd2;

    localparam logic [1:0] CMD_IGNORE = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_STORE  = 2'd2;
    localparam logic [1:0] CMD_MODIFY = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       item_hits;
        logic             item_misses;
        logic             item_evictions;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] eviction_count;
    } out_item_t;
endpackage

### src/set_assoc_lru_cache_model_top.sv
// Set-associative LRU cache tag model, top level.
// Depends on salc_pkg. Tag and stamp state live in per-way memories, valid bits in one per-set memory.
//
// Usage: items (command, address) enter on s_valid/s_ready; one result item per
// input leaves on m_valid/m_ready with per-item hit/miss/eviction flags and
// saturating running totals. Configuration is written via cfg_we/cfg_index/
// cfg_wdata while idle.
// Each access reads one set (all ways in parallel) from the line memories
// in ST_READ, then compares, picks the victim and writes back in ST_EVAL.
// ST_OUT then forms the result, and a new item is taken only in ST_IDLE, so
// an item is not taken before the last one has left ST_OUT. The second
// access of a modify rereads the set after the first write-back, so no
// forwarding is needed.
// Reset: a clearing pass runs over MAX_SETS sets, one set per cycle, while
// s_ready stays low; totals and the record clock reset to zero.
// Stall: the result sits in an output register; a new item is taken once it
// has been handed on or while it is being taken.
module set_assoc_lru_cache_model_top
    import salc_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);
    localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SMAX = $clog2(MAX_SETS + 1) - ((MAX_SETS & (MAX_SETS - 1)) != 0 ? 1 : 0)
                          - ((MAX_SETS & (MAX_SETS - 1)) == 0 ? 1 : 0);
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [3:0] set_bits_reg;
    logic [5:0] off_bits_reg;
    logic [3:0] ways_reg;

    logic [2:0] state_reg;
    logic [SET_AW:0] clr_reg;
    logic [63:0] addr_reg;
    logic [1:0] todo_reg;
    logic [1:0] hits_reg;
    logic miss_reg, evict_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic [CNT_W-1:0] hit_tot_reg, miss_tot_reg, evict_tot_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    logic [TAG_W-1:0] tag_mem [MAX_WAYS][MAX_SETS];
    logic [STAMP_W-1:0] stamp_mem [MAX_WAYS][MAX_SETS];
    logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];

    logic [TAG_W-1:0] rd_tag [MAX_WAYS];
    logic [STAMP_W-1:0] rd_stamp [MAX_WAYS];
    logic [MAX_WAYS-1:0] rd_valid;

    // effective configuration
    logic [4:0] s_eff;
    logic [5:0] w_eff;
    logic [6:0] sh;
    logic [TAG_W-1:0] tag_c;
    logic [SET_AW-1:0] set_c;
    logic [63:0] set_full;

    always_comb begin
        s_eff = (32'(set_bits_reg) > SMAX) ? 5'(SMAX) : {1'b0, set_bits_reg};
        if (ways_reg == 4'd0) w_eff = 6'd1;
        else if (32'(ways_reg) > MAX_WAYS) w_eff = 6'(MAX_WAYS);
        else w_eff = {2'b0, ways_reg};
        sh = 7'(off_bits_reg) + 7'(s_eff);
        tag_c = (sh >= 7'd64) ? '0 : (addr_reg >> sh);
        set_full = (addr_reg >> off_bits_reg) & ((64'd1 << s_eff) - 64'd1);
        set_c = SET_AW'(set_full);
    end

    // hit / fill / victim
    logic hit;
    logic [WAY_W-1:0] hit_way, free_way, old_way, sel_way;
    logic any_free;
    logic [STAMP_W-1:0] oldest;
    logic [STAMP_W-1:0] age;

    always_comb begin
        hit = 1'b0; hit_way = '0; any_free = 1'b0; free_way = '0;
        old_way = '0; oldest = '0; age = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (i < w_eff) begin
                if (rd_valid[i] && rd_tag[i] == tag_c) begin
                    hit = 1'b1; hit_way = WAY_W'(i);
                end
                if (!rd_valid[i]) begin
                    any_free = 1'b1; free_way = WAY_W'(i);
                end
            end
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            age = clock_reg - rd_stamp[i];
            if (i < w_eff && age > oldest) begin
                oldest = age; old_way = WAY_W'(i);
            end
        end
        sel_way = hit ? hit_way : (any_free ? free_way : old_way);
    end

    logic rd_en;
    logic wr_en;
    assign rd_en = (state_reg == ST_READ);
    assign wr_en = (state_reg == ST_EVAL);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (rd_en) begin
                rd_tag[i] <= tag_mem[i][set_c];
                rd_stamp[i] <= stamp_mem[i][set_c];
            end
            if (wr_en && sel_way == WAY_W'(i)) begin
                tag_mem[i][set_c] <= tag_c;
                stamp_mem[i][set_c] <= clock_reg;
            end
        end
        if (rd_en) rd_valid <= valid_mem[set_c];
        if (state_reg == ST_CLEAR) begin
            valid_mem[SET_AW'(clr_reg)] <= '0;
        end else if (wr_en) begin
            valid_mem[set_c] <= rd_valid | (MAX_WAYS'(1) << sel_way);
        end
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg <= 4'd4;
            off_bits_reg <= 6'd4;
            ways_reg <= 4'd1;
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            clock_reg <= '0;
            hit_tot_reg <= '0;
            miss_tot_reg <= '0;
            evict_tot_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            todo_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SET_BITS: set_bits_reg <= cfg_wdata[3:0];
                    CFG_OFF_BITS: off_bits_reg <= cfg_wdata;
                    CFG_WAYS:     ways_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == MAX_SETS - 1) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        addr_reg <= s_data.address;
                        hits_reg <= '0; miss_reg <= 1'b0; evict_reg <= 1'b0;
                        if (s_data.command == CMD_IGNORE) begin
                            todo_reg <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            todo_reg <= (s_data.command == CMD_MODIFY) ? 2'd2 : 2'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: state_reg <= ST_EVAL;
                ST_EVAL: begin
                    if (hit) begin
                        hits_reg <= hits_reg + 1'b1;
                        hit_tot_reg <= sat_inc(hit_tot_reg);
                    end else begin
                        miss_reg <= 1'b1;
                        miss_tot_reg <= sat_inc(miss_tot_reg);
                        if (!any_free) begin
                            evict_reg <= 1'b1;
                            evict_tot_reg <= sat_inc(evict_tot_reg);
                        end
                    end
                    todo_reg <= todo_reg - 1'b1;
                    state_reg <= (todo_reg == 2'd2) ? ST_READ : ST_OUT;
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_reg.item_hits <= hits_reg;
                    out_reg.item_misses <= miss_reg;
                    out_reg.item_evictions <= evict_reg;
                    out_reg.hit_count <= hit_tot_reg;
                    out_reg.miss_count <= miss_tot_reg;
                    out_reg.eviction_count <= evict_tot_reg;
                    clock_reg <= clock_reg + 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### src/salc_checker.sv
// Port-level checker for the cache tag model, bound to the top level.
// Depends on salc_pkg.
module salc_checker
    import salc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed under stall");
    a_no_ready_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted back to back");
    a_hits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.item_hits != 2'd3 && !(m_data.item_evictions && !m_data.item_misses))
        else $error("inconsistent per-item flags");
    a_totals_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && $past(aresetn, 2) |-> m_data.hit_count >= $past(m_data.hit_count))
        else $error("hit total decreased");
endmodule

bind set_assoc_lru_cache_model_top salc_checker u_salc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

### tb/tb_salc_checker.sv
// Checker for the set-associative LRU cache tag model: mirrors the line state,
// predicts each result item and compares it with what leaves the block.
// Depends on salc_pkg.
module tb_salc_checker
    import salc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_wdata,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        pending,
    output int        results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS = 1024;
    localparam int WAYS = 8;

    typedef enum {LINE_HIT, LINE_FILL, LINE_EVICT} line_outcome_t;

    logic [3:0]  set_bits_reg;
    logic [5:0]  off_bits_reg;
    logic [3:0]  ways_reg;
    logic        mirror_valid [SETS*WAYS];
    logic [63:0] mirror_tag   [SETS*WAYS];
    logic [31:0] mirror_stamp [SETS*WAYS];
    logic [31:0] rec_clock;
    logic [31:0] hits_sum, misses_sum, evicts_sum;
    out_item_t   expected_results [$];

    assign pending = expected_results.size();

    function automatic logic [31:0] sat_add1(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic line_outcome_t touch_line(logic [63:0] addr);
        int unsigned s, b, w, sh, base, victim;
        logic [63:0] tag, set_no;
        logic [31:0] age, oldest;
        s = (set_bits_reg > 10) ? 10 : set_bits_reg;
        b = off_bits_reg;
        w = (ways_reg == 0) ? 1 : ((ways_reg > WAYS) ? WAYS : ways_reg);
        sh = b + s;
        tag = (sh >= 64) ? 64'd0 : (addr >> sh);
        set_no = (addr >> b) & ((64'd1 << s) - 64'd1);
        base = 32'(set_no * WAYS);
        for (int i = 0; i < w; i++) begin
            if (mirror_valid[base+i] && mirror_tag[base+i] == tag) begin
                mirror_stamp[base+i] = rec_clock;
                return LINE_HIT;
            end
        end
        for (int i = 0; i < w; i++) begin
            if (!mirror_valid[base+i]) begin
                mirror_valid[base+i] = 1'b1;
                mirror_tag[base+i] = tag;
                mirror_stamp[base+i] = rec_clock;
                return LINE_FILL;
            end
        end
        victim = 0;
        oldest = 0;
        for (int i = 0; i < w; i++) begin
            age = rec_clock - mirror_stamp[base+i];
            if (age > oldest) begin
                oldest = age;
                victim = i;
            end
        end
        mirror_tag[base+victim] = tag;
        mirror_stamp[base+victim] = rec_clock;
        return LINE_EVICT;
    endfunction

    function automatic out_item_t predict_record(in_item_t it);
        out_item_t r;
        int n;
        line_outcome_t oc;
        logic [1:0] h;
        logic m, e;
        h = 0;
        m = 0;
        e = 0;
        n = (it.command == CMD_IGNORE) ? 0 : ((it.command == CMD_MODIFY) ? 2 : 1);
        for (int k = 0; k < n; k++) begin
            oc = touch_line(it.address);
            if (oc == LINE_HIT) begin
                h++;
                hits_sum = sat_add1(hits_sum);
            end else begin
                m = 1'b1;
                misses_sum = sat_add1(misses_sum);
                if (oc == LINE_EVICT) begin
                    e = 1'b1;
                    evicts_sum = sat_add1(evicts_sum);
                end
            end
        end
        rec_clock++;
        r.item_hits = h;
        r.item_misses = m;
        r.item_evictions = e;
        r.hit_count = hits_sum;
        r.miss_count = misses_sum;
        r.eviction_count = evicts_sum;
        return r;
    endfunction

    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, field, want, got);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        results_seen = 0;
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            set_bits_reg = 4;
            off_bits_reg = 4;
            ways_reg = 1;
            for (int i = 0; i < SETS*WAYS; i++) mirror_valid[i] = 1'b0;
            rec_clock = 0;
            hits_sum = 0;
            misses_sum = 0;
            evicts_sum = 0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SET_BITS: set_bits_reg = cfg_wdata[3:0];
                    CFG_OFF_BITS: off_bits_reg = cfg_wdata;
                    CFG_WAYS:     ways_reg = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.item_hits !== want.item_hits)
                        report("item_hits", want.item_hits, m_data.item_hits);
                    if (m_data.item_misses !== want.item_misses)
                        report("item_misses", want.item_misses, m_data.item_misses);
                    if (m_data.item_evictions !== want.item_evictions)
                        report("item_evictions", want.item_evictions, m_data.item_evictions);
                    if (m_data.hit_count !== want.hit_count)
                        report("hit_count", want.hit_count, m_data.hit_count);
                    if (m_data.miss_count !== want.miss_count)
                        report("miss_count", want.miss_count, m_data.miss_count);
                    if (m_data.eviction_count !== want.eviction_count)
                        report("eviction_count", want.eviction_count, m_data.eviction_count);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_record(s_data));
        end
    end
endmodule

### tb/tb_set_assoc_lru_cache_model_top.sv
// Testbench top for the set-associative LRU cache tag model: drives trace
// records and configuration, stalls both sides, and gives the verdict.
// Depends on salc_pkg, tb_salc_checker and set_assoc_lru_cache_model_top.
module tb_set_assoc_lru_cache_model_top;
    import salc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 300;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_SET_BITS;
    logic [5:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    int fail_count, pending, results_seen;
    int items_sent = 0;
    int idle_cycles = 0;
    bit hold_request = 0;
    int cur_sets, cur_off, cur_ways;

    always #5 aclk = ~aclk;

    set_assoc_lru_cache_model_top u_dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    tb_salc_checker u_checker (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .fail_count, .pending, .results_seen
    );

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: stretches of always-ready, random stalls, or long stalls
    initial begin
        int stretch, mode;
        forever begin
            stretch = $urandom_range(5, 60);
            mode = $urandom_range(0, 9);
            repeat (stretch) begin
                @(posedge aclk);
                if (hold_request) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_request = 0;
                end
                if (mode < 4)
                    m_ready <= 1'b1;
                else if (mode < 9)
                    m_ready <= ($urandom_range(0, 2) != 0);
                else
                    m_ready <= ($urandom_range(0, 15) == 0);
            end
        end
    end

    task automatic send_record(logic [1:0] cmd, logic [63:0] addr);
        int gap;
        s_valid <= 1'b1;
        s_data <= '{command: cmd, address: addr};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        gap = ($urandom_range(0, 9) < 7) ? 0 :
              (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_config(int sets, int off, int ways);
        cur_sets = sets;
        cur_off = off;
        cur_ways = ways;
        cfg_we <= 1'b1;
        cfg_index <= CFG_SET_BITS;
        cfg_wdata <= 6'(sets);
        @(posedge aclk);
        cfg_index <= CFG_OFF_BITS;
        cfg_wdata <= 6'(off);
        @(posedge aclk);
        cfg_index <= CFG_WAYS;
        cfg_wdata <= 6'(ways);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly addresses that land on a few sets with a few tags, so lines hit and evict
    function automatic logic [63:0] trace_address();
        int unsigned s, w;
        logic [63:0] tag, set_no, offs;
        s = (cur_sets > 10) ? 10 : cur_sets;
        w = (cur_ways == 0) ? 1 : ((cur_ways > 8) ? 8 : cur_ways);
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        tag = 64'($urandom_range(0, w + 2));
        if ($urandom_range(0, 15) == 0)
            tag = {$urandom, $urandom};
        set_no = 64'($urandom_range(0, 3));
        offs = {$urandom, $urandom} & ((64'd1 << cur_off) - 64'd1);
        return (tag << (cur_off + s)) | (set_no << cur_off) | offs;
    endfunction

    initial begin
        int cfg_list [8][3] = '{
            '{0, 0, 1}, '{10, 6, 8}, '{15, 32, 3}, '{3, 63, 0},
            '{12, 0, 15}, '{2, 5, 4}, '{10, 54, 2}, '{1, 3, 8}
        };
        cur_sets = 4;
        cur_off = 4;
        cur_ways = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_record(CMD_IGNORE, 64'd0);
        send_record(CMD_LOAD, 64'd0);
        send_record(CMD_LOAD, 64'd0);
        send_record(CMD_STORE, 64'hF);
        send_record(CMD_MODIFY, '1);
        send_record(CMD_LOAD, 64'h100);
        send_record(CMD_MODIFY, 64'd0);
        send_record(CMD_IGNORE, '1);
        send_record(CMD_STORE, 64'h5555_5555_5555_5555);
        send_record(CMD_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_record(CMD_MODIFY, 64'h8000_0000_0000_0000);
        send_record(CMD_LOAD, 64'h8000_0000_0000_0000);
        send_record(CMD_STORE, 64'h10);
        send_record(CMD_MODIFY, 64'h10);
        send_record(CMD_LOAD, 64'h7FFF_FFFF_FFFF_FFF0);
        settle();

        foreach (cfg_list[p]) begin
            write_config(cfg_list[p][0], cfg_list[p][1], cfg_list[p][2]);
            if (p == 2)
                hold_request = 1;
            repeat (192) send_record(2'($urandom_range(0, 3)), trace_address());
            settle();
        end
        write_config(4, 4, 1);
        repeat (20) send_record(2'($urandom_range(0, 3)), trace_address());
        settle();

        $display("covered %0d trace records over %0d cache shapes, %0d result items checked",
                 items_sent, 10, results_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### set_assoc_lru_cache_model_top.f
src/salc_pkg.sv
src/set_assoc_lru_cache_model_top.sv
src/salc_checker.sv
tb/tb_salc_checker.sv
tb/tb_set_assoc_lru_cache_model_top.sv
